[hdl/gswg_pkg.sv]
// Shared types, codes and constants of the grid scan waypoint generator.
package gswg_pkg;

  localparam int MAX_GRID_DIM_DEF = 256;

  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int FRAC_BITS  = 12;
  localparam int ID_W       = 8;
  localparam int CFG_DIM_W  = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = DIFF_W + FRAC_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int Q_W        = ACC_W + 1 - FRAC_BITS;
  localparam int MAC_STEPS  = 4;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_E = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_N = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_XAXIS_E  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_XAXIS_N  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_YAXIS_E  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_YAXIS_N  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_COLS     = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROWS     = 3'd7;

  // Multiply-accumulate step codes: axis product per coordinate
  localparam logic [1:0] MAC_EAST_X  = 2'd0;
  localparam logic [1:0] MAC_EAST_Y  = 2'd1;
  localparam logic [1:0] MAC_NORTH_X = 2'd2;
  localparam logic [1:0] MAC_NORTH_Y = 2'd3;

  typedef enum logic [1:0] {
    OP_NEXT    = 2'd0,
    OP_POS     = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [ID_W-1:0]           wp_id;
    logic signed [FRAC_W-1:0]  frac_x;
    logic signed [FRAC_W-1:0]  frac_y;
  } gswg_in_t;

  typedef struct packed {
    logic [ID_W-1:0]           out_wp_id;
    logic signed [COORD_W-1:0] east;
    logic signed [COORD_W-1:0] north;
    logic                      grid_done;
  } gswg_out_t;

  typedef struct packed {
    logic       take;
    logic       div_step;
    logic       store_x;
    logic       init_y;
    logic       store_y;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic       rnd_en;
    logic       out_load;
  } gswg_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_DIVF,
    S_MUL,
    S_RND,
    S_OUT
  } state_t;

endpackage

[hdl/gswg_ctrl.sv]
// Sequencer of the waypoint generator: steps the divider, the MAC and the output register.
module gswg_ctrl import gswg_pkg::*; #(
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  op_t       in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output gswg_cmd_t cmd
);

  localparam int NUM_W = $clog2(MAX_GRID_DIM) + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.take = 1'b1;
          case (in_op)
            OP_NEXT: state_nxt = S_DIVX;
            OP_POS:  state_nxt = S_MUL;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIVX: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (cnt_r == '0) begin
          cmd.store_x = 1'b1;
          cmd.init_y  = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIVF;
        end
      end
      S_DIVF: begin
        cmd.store_y = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        if (cnt_r < CNT_W'(MAC_STEPS)) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = cnt_r[1:0];
        end
        if (cnt_r != '0) begin
          cmd.acc_en  = 1'b1;
          cmd.acc_sel = 2'(cnt_r - 1'b1);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAC_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/gswg_dp.sv]
// Datapath of the waypoint generator: registers, grid position, divider, MAC, rounding.
module gswg_dp import gswg_pkg::*; #(
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COORD_W-1:0]    cfg_data,
  input  gswg_in_t              in_data,
  input  gswg_cmd_t             cmd,
  output gswg_out_t             out_data
);

  localparam int IDX_W = $clog2(MAX_GRID_DIM);
  localparam int DIM_W = $clog2(MAX_GRID_DIM + 1);
  localparam int CMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int NUM_W = IDX_W + FRAC_BITS;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] raw);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(raw);
    if (ext == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (ext > CMP_W'(MAX_GRID_DIM)) begin
      clamp_dim = DIM_W'(MAX_GRID_DIM);
    end else begin
      clamp_dim = DIM_W'(ext);
    end
  endfunction

  function automatic logic [NUM_W-1:0] grid_num(input logic [IDX_W-1:0] idx,
                                                input logic [IDX_W-1:0] den);
    grid_num = (NUM_W'(idx) << FRAC_BITS) + NUM_W'(den >> 1);
  endfunction

  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] org,
                                                 input logic [Q_W-1:0]     q);
    logic [Q_W:0] s;
    s = {{(Q_W + 1 - COORD_W){org[COORD_W-1]}}, org} + {q[Q_W-1], q};
    if ((&s[Q_W:COORD_W-1]) || !(|s[Q_W:COORD_W-1])) begin
      sat_add = s[COORD_W-1:0];
    end else if (s[Q_W]) begin
      sat_add = {1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      sat_add = {1'b0, {(COORD_W - 1){1'b1}}};
    end
  endfunction

  // Configuration and grid position
  logic [COORD_W-1:0]   org_e_r, org_n_r, xe_r, xn_r, ye_r, yn_r;
  logic [CFG_DIM_W-1:0] cols_raw_r, rows_raw_r;
  logic [IDX_W-1:0]     col_r, row_r;

  // Work registers
  logic [ID_W-1:0]          wp_r;
  logic                     done_r;
  logic [IDX_W-1:0]         rowl_r;
  logic signed [FRAC_W-1:0] fx_r, fy_r;
  logic [NUM_W-1:0]         num_r;
  logic [IDX_W-1:0]         rem_r, den_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_e_r, acc_n_r;
  logic [Q_W-1:0]           qe_r, qn_r;
  gswg_out_t                out_r;

  logic [DIM_W-1:0] cols, rows;
  logic [IDX_W-1:0] den_x, den_y;
  logic [IDX_W-1:0] col_adv, row_adv;
  logic             at_last, adv_last;

  assign cols  = clamp_dim(cols_raw_r);
  assign rows  = clamp_dim(rows_raw_r);
  assign den_x = IDX_W'(cols - 1'b1);
  assign den_y = IDX_W'(rows - 1'b1);

  // Advance row-major, hold at the last point
  always_comb begin
    at_last = (DIM_W'(col_r) + 1'b1 >= cols) && (DIM_W'(row_r) + 1'b1 >= rows);
    col_adv = col_r;
    row_adv = row_r;
    if (!at_last) begin
      if (DIM_W'(col_r) + 1'b1 < cols) begin
        col_adv = col_r + 1'b1;
      end else begin
        col_adv = '0;
        row_adv = row_r + 1'b1;
      end
    end
    adv_last = (DIM_W'(col_adv) + 1'b1 >= cols) && (DIM_W'(row_adv) + 1'b1 >= rows);
  end

  // Restoring divider, one quotient bit per step
  logic [IDX_W:0]        rem_sh, rem_dif;
  logic                  ge;
  logic [FRAC_W-1:0]     qfrac;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign qfrac   = FRAC_W'(num_r[FRAC_BITS:0]);

  // Shared multiplier
  logic signed [DIFF_W-1:0] d_xe, d_ye, d_xn, d_yn, mul_a;
  logic signed [FRAC_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  prod_ext;

  assign d_xe = $signed({xe_r[COORD_W-1], xe_r}) - $signed({org_e_r[COORD_W-1], org_e_r});
  assign d_ye = $signed({ye_r[COORD_W-1], ye_r}) - $signed({org_e_r[COORD_W-1], org_e_r});
  assign d_xn = $signed({xn_r[COORD_W-1], xn_r}) - $signed({org_n_r[COORD_W-1], org_n_r});
  assign d_yn = $signed({yn_r[COORD_W-1], yn_r}) - $signed({org_n_r[COORD_W-1], org_n_r});

  always_comb begin
    case (cmd.mul_sel)
      MAC_EAST_X: begin
        mul_a = d_xe;
        mul_b = fx_r;
      end
      MAC_EAST_Y: begin
        mul_a = d_ye;
        mul_b = fy_r;
      end
      MAC_NORTH_X: begin
        mul_a = d_xn;
        mul_b = fx_r;
      end
      MAC_NORTH_Y: begin
        mul_a = d_yn;
        mul_b = fy_r;
      end
      default: begin
        mul_a = d_xe;
        mul_b = fx_r;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_ext = {prod_r[PROD_W-1], prod_r};

  logic signed [ACC_W:0] rnd_e, rnd_n;
  assign rnd_e = {acc_e_r[ACC_W-1], acc_e_r} + (ACC_W + 1)'(ROUND_HALF);
  assign rnd_n = {acc_n_r[ACC_W-1], acc_n_r} + (ACC_W + 1)'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_e_r    <= '0;
      org_n_r    <= '0;
      xe_r       <= '0;
      xn_r       <= '0;
      ye_r       <= '0;
      yn_r       <= '0;
      cols_raw_r <= CFG_DIM_W'(2);
      rows_raw_r <= CFG_DIM_W'(2);
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ORIGIN_E: org_e_r <= cfg_data;
        CFG_ORIGIN_N: org_n_r <= cfg_data;
        CFG_XAXIS_E:  xe_r    <= cfg_data;
        CFG_XAXIS_N:  xn_r    <= cfg_data;
        CFG_YAXIS_E:  ye_r    <= cfg_data;
        CFG_YAXIS_N:  yn_r    <= cfg_data;
        CFG_COLS: begin
          cols_raw_r <= cfg_data[CFG_DIM_W-1:0];
          col_r      <= '0;
          row_r      <= '0;
        end
        CFG_ROWS: begin
          rows_raw_r <= cfg_data[CFG_DIM_W-1:0];
          col_r      <= '0;
          row_r      <= '0;
        end
        default: ;
      endcase
    end else if (cmd.take) begin
      case (in_data.op)
        OP_NEXT: begin
          col_r <= col_adv;
          row_r <= row_adv;
        end
        OP_RESTART: begin
          col_r <= '0;
          row_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      wp_r <= in_data.wp_id;
      if (in_data.op == OP_NEXT) begin
        done_r <= adv_last;
        rowl_r <= row_r;
        num_r  <= grid_num(col_r, den_x);
        rem_r  <= '0;
        den_r  <= den_x;
      end else begin
        done_r <= at_last;
        fx_r   <= in_data.frac_x;
        fy_r   <= in_data.frac_y;
      end
    end else if (cmd.init_y) begin
      num_r <= grid_num(rowl_r, den_y);
      rem_r <= '0;
      den_r <= den_y;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_dif[IDX_W-1:0] : rem_sh[IDX_W-1:0];
    end

    // Single-point axis: fraction is zero
    if (cmd.store_x) begin
      fx_r <= (cols == DIM_W'(1)) ? '0 : qfrac;
    end
    if (cmd.store_y) begin
      fy_r <= (rows == DIM_W'(1)) ? '0 : qfrac;
    end

    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_en) begin
      case (cmd.acc_sel)
        MAC_EAST_X:  acc_e_r <= prod_ext;
        MAC_EAST_Y:  acc_e_r <= acc_e_r + prod_ext;
        MAC_NORTH_X: acc_n_r <= prod_ext;
        MAC_NORTH_Y: acc_n_r <= acc_n_r + prod_ext;
        default: ;
      endcase
    end

    if (cmd.rnd_en) begin
      qe_r <= rnd_e[ACC_W:FRAC_BITS];
      qn_r <= rnd_n[ACC_W:FRAC_BITS];
    end

    if (cmd.out_load) begin
      out_r.out_wp_id <= wp_r;
      out_r.east      <= sat_add(org_e_r, qe_r);
      out_r.north     <= sat_add(org_n_r, qn_r);
      out_r.grid_done <= done_r;
    end
  end

  assign out_data = out_r;

endmodule

[hdl/grid_scan_waypoint_generator_core.sv]
// Top level of the grid scan waypoint generator: sequencer plus datapath.
// Op next: the two grid fractions go through one bit-serial divider on a dividend of NUM_W =
//   ceil(log2(MAX_GRID_DIM)) + 12 bits, then the same steps as op pos.
// Op pos: four shared multiplier passes, rounding, output load; restart: resets the position only.
// One item at a time; the next transfer can be taken once the result is in the
//   output register, while that result may still wait for out_ready.
// Reset (rst_n low, synchronous) clears the position, config registers (dimensions to 2), out_valid.
module grid_scan_waypoint_generator_core import gswg_pkg::*; #(
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COORD_W-1:0]    cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gswg_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gswg_out_t             out_data
);

  gswg_cmd_t cmd;

  // Sequencer: accepts a transfer only when idle, walks divide, MAC, round, load
  gswg_ctrl #(
    .MAX_GRID_DIM(MAX_GRID_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  // Datapath: holds the registers and position, advances the scan at transfer,
  // maps fractions through the plane and saturates into the output register
  gswg_dp #(
    .MAX_GRID_DIM(MAX_GRID_DIM)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .in_data (in_data),
    .cmd     (cmd),
    .out_data(out_data)
  );

endmodule

[verif/gswg_waypoint_checker.sv]
// Checker for the grid scan waypoint generator: tracks configuration, predicts and compares.
module gswg_waypoint_checker import gswg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COORD_W-1:0]    cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  gswg_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  gswg_out_t             out_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int unsigned DIM_LIMIT = MAX_GRID_DIM_DEF;
  localparam longint      COORD_MAX = 64'sd2147483647;
  localparam longint      COORD_MIN = -COORD_MAX - 1;

  logic [COORD_W-1:0]   geo_reg [0:5];
  logic [CFG_DIM_W-1:0] cols_reg;
  logic [CFG_DIM_W-1:0] rows_reg;
  int unsigned          col_pos;
  int unsigned          row_pos;
  gswg_out_t            waypoint_q [$];
  gswg_out_t            wp_want;

  function automatic int unsigned clamp_dim(logic [CFG_DIM_W-1:0] d);
    if (d == '0) return 1;
    if (d > DIM_LIMIT) return DIM_LIMIT;
    return d;
  endfunction

  // Round half up of index/(dim-1) in Q4.12
  function automatic longint grid_frac(int unsigned idx, int unsigned dim);
    int unsigned den;
    if (dim <= 1) return 0;
    den = dim - 1;
    return longint'((idx * 4096 + den / 2) / den);
  endfunction

  function automatic logic [COORD_W-1:0] map_coord(longint org, longint ax, longint ay,
                                                   longint fx, longint fy);
    longint acc;
    longint r;
    acc = fx * (ax - org) + fy * (ay - org);
    r = org + ((acc + 2048) >>> FRAC_BITS);
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < COORD_MIN) r = COORD_MIN;
    return r[COORD_W-1:0];
  endfunction

  function automatic longint coord(logic [COORD_W-1:0] v);
    return longint'($signed(v));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic plan_waypoint(input gswg_in_t it);
    int unsigned cols;
    int unsigned rows;
    longint      fx;
    longint      fy;
    gswg_out_t   wp;
    cols = clamp_dim(cols_reg);
    rows = clamp_dim(rows_reg);
    case (it.op)
      OP_RESTART: begin
        col_pos = 0;
        row_pos = 0;
      end
      OP_NEXT, OP_POS: begin
        if (it.op == OP_NEXT) begin
          fx = grid_frac(col_pos, cols);
          fy = grid_frac(row_pos, rows);
          // advance row-major, hold at the last point
          if (!(col_pos + 1 >= cols && row_pos + 1 >= rows)) begin
            if (col_pos + 1 < cols) begin
              col_pos++;
            end else begin
              col_pos = 0;
              row_pos++;
            end
          end
        end else begin
          fx = longint'($signed(it.frac_x));
          fy = longint'($signed(it.frac_y));
        end
        wp.out_wp_id = it.wp_id;
        wp.east      = map_coord(coord(geo_reg[CFG_ORIGIN_E]), coord(geo_reg[CFG_XAXIS_E]),
                                 coord(geo_reg[CFG_YAXIS_E]), fx, fy);
        wp.north     = map_coord(coord(geo_reg[CFG_ORIGIN_N]), coord(geo_reg[CFG_XAXIS_N]),
                                 coord(geo_reg[CFG_YAXIS_N]), fx, fy);
        wp.grid_done = (col_pos + 1 >= cols) && (row_pos + 1 >= rows);
        waypoint_q.push_back(wp);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) geo_reg[i] = '0;
      cols_reg = 9'd2;
      rows_reg = 9'd2;
      col_pos  = 0;
      row_pos  = 0;
      waypoint_q.delete();
    end else begin
      // compare the result before queueing a new item at the same edge
      if (out_valid && out_ready) begin
        if (waypoint_q.size() == 0) begin
          report_mismatch("result with nothing expected, wp_id", out_data.out_wp_id, 0);
        end else begin
          wp_want = waypoint_q.pop_front();
          if (out_data.out_wp_id !== wp_want.out_wp_id)
            report_mismatch("out_wp_id", out_data.out_wp_id, wp_want.out_wp_id);
          if (out_data.east !== wp_want.east)
            report_mismatch("east", out_data.east, wp_want.east);
          if (out_data.north !== wp_want.north)
            report_mismatch("north", out_data.north, wp_want.north);
          if (out_data.grid_done !== wp_want.grid_done)
            report_mismatch("grid_done", out_data.grid_done, wp_want.grid_done);
        end
      end
      if (in_valid && in_ready) plan_waypoint(in_data);
      if (cfg_we) begin
        case (cfg_addr)
          CFG_COLS: begin
            cols_reg = cfg_data[CFG_DIM_W-1:0];
            col_pos  = 0;
            row_pos  = 0;
          end
          CFG_ROWS: begin
            rows_reg = cfg_data[CFG_DIM_W-1:0];
            col_pos  = 0;
            row_pos  = 0;
          end
          default: geo_reg[cfg_addr] = cfg_data;
        endcase
      end
    end
    pending <= waypoint_q.size();
  end

endmodule

[verif/tb_grid_scan_waypoint_generator_core.sv]
// Testbench top for the grid scan waypoint generator: stimulus, watchdog and verdict.
module tb_grid_scan_waypoint_generator_core;
  import gswg_pkg::*;

  // Longest quiet spell of a correct run is the settle wait, or a divide at the 256 grid limit
  // plus an output stall; allow many times that.
  localparam int          QUIET_LIMIT    = 2000;
  // Settle time before a register write: covers the longest item latency.
  localparam int          SETTLE_CYCLES  = 64;
  localparam int          PHASES         = 8;
  localparam int          PHASE_ITEMS    = 60;
  localparam int          IDLE_PCT       = 24;
  localparam logic [1:0]  OP_SPARE       = 2'd3;
  localparam logic [31:0] COORD_LO       = 32'h8000_0000;
  localparam logic [31:0] COORD_HI       = 32'h7FFF_FFFF;
  localparam logic signed [15:0] FRAC_ONE = 16'sd4096;
  localparam logic signed [15:0] FRAC_LO  = 16'sh8000;
  localparam logic signed [15:0] FRAC_HI  = 16'sh7FFF;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [COORD_W-1:0]    cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  gswg_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  gswg_out_t             out_data;

  int                    fail_count;
  int                    pending;
  int                    quiet_cycles;
  // set during a stretch that runs with no idling on either side
  logic                  calm;

  always #5 clk = ~clk;

  grid_scan_waypoint_generator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  gswg_waypoint_checker waypoint_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Result side: stall at random, never during the calm stretch.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic gswg_in_t make_item(logic [1:0] op, logic [7:0] id,
                                         logic signed [15:0] fx, logic signed [15:0] fy);
    gswg_in_t it;
    it.op     = op_t'(op);
    it.wp_id  = id;
    it.frac_x = fx;
    it.frac_y = fy;
    return it;
  endfunction

  // Mostly walk the grid; mix in explicit positions, restarts and the spare code.
  function automatic gswg_in_t random_item();
    gswg_in_t    it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    it = make_item(OP_NEXT, 8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom));
    if (roll >= 55 && roll < 85) begin
      it.op = OP_POS;
      // half of the positions stay inside the grid
      if ($urandom_range(0, 1)) begin
        it.frac_x = 16'($urandom_range(0, FRAC_ONE));
        it.frac_y = 16'($urandom_range(0, FRAC_ONE));
      end
    end else if (roll >= 85 && roll < 95) begin
      it.op = OP_RESTART;
    end else if (roll >= 95) begin
      it.op = op_t'(OP_SPARE);
    end
    return it;
  endfunction

  // Hold valid with a fixed payload until the transfer; idle between items at random.
  task automatic push_item(input gswg_in_t it);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, drain every expected result, then let a silent item finish.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = addr;
    cfg_data = data;
  endtask

  // Write all eight registers back to back, then release the write enable.
  task automatic write_geometry(input logic [31:0] oe, input logic [31:0] on,
                                input logic [31:0] xe, input logic [31:0] xn,
                                input logic [31:0] ye, input logic [31:0] yn,
                                input logic [31:0] cols, input logic [31:0] rows);
    write_reg(CFG_ORIGIN_E, oe);
    write_reg(CFG_ORIGIN_N, on);
    write_reg(CFG_XAXIS_E, xe);
    write_reg(CFG_XAXIS_N, xn);
    write_reg(CFG_YAXIS_E, ye);
    write_reg(CFG_YAXIS_N, yn);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Coordinate within about +/-4096 m, so sums rarely saturate.
  function automatic logic [31:0] near_coord();
    return int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
  endfunction

  initial begin
    int sent;
    gswg_in_t it;

    // Drive every input to a known value before the first edge.
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data  = '0;
    calm     = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: walk a 3 x 2 grid past its last point, restart, then explicit positions.
    write_geometry(32'h0000_1000, -32'sh2000, 32'h0004_1000, 32'h0000_3000,
                   -32'sh5000, 32'h0002_2000, 32'd3, 32'd2);
    repeat (7) push_item(make_item(OP_NEXT, 8'd7, '0, '0));
    push_item(make_item(OP_RESTART, 8'd1, '0, '0));
    push_item(make_item(OP_NEXT, 8'd0, FRAC_HI, FRAC_LO));
    push_item(make_item(OP_POS, 8'd255, '0, '0));
    push_item(make_item(OP_POS, 8'd128, FRAC_ONE, FRAC_ONE));
    push_item(make_item(OP_POS, 8'd64, FRAC_LO, FRAC_LO));
    push_item(make_item(OP_POS, 8'd63, FRAC_HI, FRAC_HI));
    push_item(make_item(OP_POS, 8'd2, FRAC_LO, FRAC_HI));
    push_item(make_item(OP_SPARE, 8'd255, FRAC_HI, FRAC_HI));
    push_item(make_item(OP_NEXT, 8'd0, '0, '0));
    wait_idle();

    // Directed: extreme corners with a one-point grid; both saturation directions.
    write_geometry(COORD_LO, COORD_HI, COORD_HI, COORD_LO, COORD_HI, COORD_LO,
                   32'd1, 32'd1);
    push_item(make_item(OP_NEXT, 8'd10, '0, '0));
    push_item(make_item(OP_POS, 8'd11, FRAC_HI, FRAC_HI));
    push_item(make_item(OP_POS, 8'd12, FRAC_LO, FRAC_LO));
    push_item(make_item(OP_RESTART, 8'd13, '0, '0));
    push_item(make_item(OP_NEXT, 8'd14, '0, '0));
    wait_idle();

    // Random phases, each with a fresh setting of every register.
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 1);
      case (p)
        0: write_geometry(near_coord(), near_coord(), near_coord(), near_coord(),
                          near_coord(), near_coord(), $urandom_range(1, 5),
                          $urandom_range(1, 5));
        1: write_geometry($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(1, 8), $urandom_range(1, 8));
        2: write_geometry(COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI, COORD_HI,
                          32'd2, 32'd3);
        3: write_geometry(COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_LO, COORD_LO,
                          32'd3, 32'd2);
        // zero and oversized dimensions are clamped by the block
        4: write_geometry(near_coord(), near_coord(), near_coord(), near_coord(),
                          near_coord(), near_coord(), 32'd0, 32'd511);
        5: write_geometry($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          32'd256, 32'd1);
        // upper data bits beyond the dimension width are don't-care
        6: write_geometry(near_coord(), near_coord(), near_coord(), near_coord(),
                          near_coord(), near_coord(),
                          {23'($urandom_range(1, 32'h7F_FFFF)), 9'd1},
                          {23'($urandom_range(1, 32'h7F_FFFF)), 9'd4});
        default: write_geometry($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom_range(0, 511), $urandom_range(0, 511));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        it = random_item();
        push_item(it);
        // the spare code is ignored by the block; do not count it
        if (it.op != op_t'(OP_SPARE)) sent++;
      end
      wait_idle();
    end
    calm = 1'b0;

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
